/* hw/rtl/dictionary_index_builder_core_assert.svh */
// assertion macros used by the port-level checker
`ifndef DICTIONARY_INDEX_BUILDER_CORE_ASSERT_SVH
`define DICTIONARY_INDEX_BUILDER_CORE_ASSERT_SVH

// same-cycle implication, sampled on the rising clock edge
`define DIB_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("dictionary index builder check failed");

// next-cycle implication, sampled on the rising clock edge
`define DIB_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("dictionary index builder check failed");

`endif

/* hw/rtl/dib_pkg.sv */
// shared types and constants of the dictionary index builder
package dib_pkg;
   localparam logic [31:0] FNV_BASIS = 32'h811c9dc5;
   localparam logic [31:0] FNV_PRIME = 32'h01000193;
   localparam int VALUE_W  = 64;
   localparam int DINDEX_W = 12;
   localparam int IWIDTH_W = 4;
   localparam int NBYTES_W = 4;
   localparam int EPOCH_W  = 8;
   // bucket count is a power of two, so the bucket is the low hash bits
   localparam int BUCKET_COUNT = 1024;
   localparam int BUCKET_W     = $clog2(BUCKET_COUNT);

   typedef enum logic [1:0] {
      HS_IDLE,
      HS_BYTES
   } hash_state_type;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_HASH,
      ST_HEAD,
      ST_ENTRY,
      ST_MISS,
      ST_FINISH
   } core_state_type;
endpackage

/* hw/rtl/dib_ram.sv */
// generic single-write, single-read ram with registered read data
module dib_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // registered read port
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;
endmodule

/* hw/rtl/dib_hash.sv */
// serial fnv-1a hash, one byte a cycle, bucket taken from the low hash bits
module dib_hash (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            start,
   input  logic [dib_pkg::VALUE_W-1:0]     value,
   input  logic [dib_pkg::NBYTES_W-1:0]    nbytes,
   output logic                            done,
   output logic [dib_pkg::BUCKET_W-1:0]    bucket
);
   dib_pkg::hash_state_type state_ff, state_in;
   logic [dib_pkg::VALUE_W-1:0]  v_ff, v_in;
   logic [dib_pkg::NBYTES_W-1:0] n_ff, n_in;
   logic [dib_pkg::NBYTES_W-1:0] cnt_ff, cnt_in;
   logic [31:0]                  h_ff, h_in;
   logic                         done_ff, done_in;
   logic [31:0]                  mix;

   // state and datapath registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= dib_pkg::HS_IDLE;
         done_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         done_ff  <= done_in;
      end
      v_ff   <= v_in;
      n_ff   <= n_in;
      cnt_ff <= cnt_in;
      h_ff   <= h_in;
   end

   // one multiply per byte
   always_comb begin
      state_in = state_ff;
      v_in     = v_ff;
      n_in     = n_ff;
      cnt_in   = cnt_ff;
      h_in     = h_ff;
      done_in  = 1'b0;
      mix      = (h_ff ^ {24'd0, v_ff[7:0]}) * dib_pkg::FNV_PRIME;
      case (state_ff)
         dib_pkg::HS_IDLE: begin
            if (start) begin
               v_in     = value;
               n_in     = nbytes;
               cnt_in   = '0;
               h_in     = dib_pkg::FNV_BASIS;
               state_in = dib_pkg::HS_BYTES;
            end
         end
         dib_pkg::HS_BYTES: begin
            h_in   = mix;
            v_in   = v_ff >> 8;
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == n_ff - 1'b1) begin
               done_in  = 1'b1;
               state_in = dib_pkg::HS_IDLE;
            end
         end
         default: begin
            state_in = dib_pkg::HS_IDLE;
         end
      endcase
   end

   assign done   = done_ff;
   assign bucket = h_ff[dib_pkg::BUCKET_W-1:0];
endmodule

/* hw/rtl/dictionary_index_builder_core.sv */
// dictionary index builder: fnv-1a bucket hash table over two rams
// steps: hash over value_bytes (taken as 4 to 8), head read, a read per chain entry,
// and a miss step that inserts unless full; a stalled result holds the block until it leaves
// items are taken one at a time; the next is accepted in idle once the result is registered
// reset: clearing pass over the bucket ram, no item accepted meanwhile;
// the same pass runs again after every 256th cleared chunk when the epoch mark wraps
module dictionary_index_builder_core #(
   parameter int MAX_ENTRIES = 4096
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_stall,
   input  logic [63:0]                      req_value,
   input  logic                             req_last_value,
   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   output logic [11:0]                      rsp_dict_index,
   output logic                             rsp_is_new,
   output logic [63:0]                      rsp_dict_value,
   output logic                             rsp_table_full,
   output logic [3:0]                       rsp_index_width,
   input  logic                             psel,
   input  logic                             penable,
   input  logic                             pwrite,
   input  logic [2:0]                       paddr,
   input  logic [31:0]                      pwdata,
   output logic [31:0]                      prdata,
   output logic                             pready
);
   localparam int BW = dib_pkg::BUCKET_W;
   localparam int IW = $clog2(MAX_ENTRIES);
   localparam int CW = $clog2(MAX_ENTRIES + 1);
   localparam int EW = dib_pkg::EPOCH_W;
   localparam int VW = dib_pkg::VALUE_W;
   localparam int NW = dib_pkg::NBYTES_W;
   localparam int HW = 1 + EW + IW;
   localparam int DW = VW + NW + 1 + IW;

   dib_pkg::core_state_type state_ff, state_in;
   logic [NW-1:0] vb_ff;
   logic [VW-1:0] v_ff, v_in;
   logic [NW-1:0] n_ff, n_in;
   logic          last_ff, last_in;
   logic [BW-1:0] bucket_ff, bucket_in;
   logic          have_ff, have_in;
   logic [IW-1:0] hidx_ff, hidx_in;
   logic [IW-1:0] cur_ff, cur_in;
   logic [CW-1:0] count_ff, count_in;
   logic [EW-1:0] epoch_ff, epoch_in;
   logic [BW-1:0] clr_ff, clr_in;
   logic [IW-1:0] ridx_ff, ridx_in;
   logic          rnew_ff, rnew_in;
   logic          rfull_ff, rfull_in;

   logic          rsp_valid_ff, rsp_valid_in;
   logic [11:0]   rsp_index_ff, rsp_index_in;
   logic          rsp_new_ff, rsp_new_in;
   logic [VW-1:0] rsp_value_ff, rsp_value_in;
   logic          rsp_full_ff, rsp_full_in;
   logic [3:0]    rsp_width_ff, rsp_width_in;

   logic          hash_start, hash_done;
   logic [BW-1:0] hash_bucket;
   logic          head_we, head_re;
   logic [BW-1:0] head_waddr, head_raddr;
   logic [HW-1:0] head_wdata, head_rdata;
   logic          ent_we, ent_re;
   logic [IW-1:0] ent_waddr, ent_raddr;
   logic [DW-1:0] ent_wdata, ent_rdata;

   logic [NW-1:0] req_n;
   logic [VW-1:0] req_mask;
   logic          head_have;
   logic [VW-1:0] ent_data;
   logic [NW-1:0] ent_n;
   logic          ent_lvalid;
   logic [IW-1:0] ent_link;
   logic          out_free;

   // bits needed for indices at a given entry count
   function automatic logic [3:0] width_for(input logic [CW-1:0] count);
      logic [CW-1:0] m;
      logic [5:0]    w;
      m = count - 1'b1;
      w = '0;
      for (int i = 0; i < CW; i++) begin
         if (m[i]) begin
            w = 6'(i + 1);
         end
      end
      if (count == '0) begin
         w = '0;
      end else if (w == '0) begin
         w = 6'd1;
      end
      return w[3:0];
   endfunction

   // hash unit
   dib_hash u_hash (
      .clock  (clock),
      .reset  (reset),
      .start  (hash_start),
      .value  (v_in),
      .nbytes (n_in),
      .done   (hash_done),
      .bucket (hash_bucket)
   );

   // bucket heads: valid, epoch mark, newest entry
   dib_ram #(.WIDTH(HW), .DEPTH(dib_pkg::BUCKET_COUNT)) u_head_ram (
      .clock   (clock),
      .wr_en   (head_we),
      .wr_addr (head_waddr),
      .wr_data (head_wdata),
      .rd_en   (head_re),
      .rd_addr (head_raddr),
      .rd_data (head_rdata)
   );

   // entries: value, byte count, link valid, link
   dib_ram #(.WIDTH(DW), .DEPTH(MAX_ENTRIES)) u_entry_ram (
      .clock   (clock),
      .wr_en   (ent_we),
      .wr_addr (ent_waddr),
      .wr_data (ent_wdata),
      .rd_en   (ent_re),
      .rd_addr (ent_raddr),
      .rd_data (ent_rdata)
   );

   // configuration register
   always_ff @(posedge clock) begin
      if (reset) begin
         vb_ff <= 4'd8;
      end else if (psel && penable && pwrite && !paddr[2]) begin
         vb_ff <= pwdata[3:0];
      end
   end

   assign pready = 1'b1;
   assign prdata = paddr[2] ? 32'd0 : {28'd0, vb_ff};

   // clamp byte count and mask the value
   always_comb begin
      if (vb_ff < 4'd4) begin
         req_n = 4'd4;
      end else if (vb_ff > 4'd8) begin
         req_n = 4'd8;
      end else begin
         req_n = vb_ff;
      end
      if (req_n >= 4'd8) begin
         req_mask = '1;
      end else begin
         req_mask = (64'd1 << {req_n, 3'b000}) - 64'd1;
      end
   end

   // ram read data fields
   assign head_have  = head_rdata[HW-1] && (head_rdata[IW +: EW] == epoch_ff);
   assign ent_data   = ent_rdata[DW-1 -: VW];
   assign ent_n      = ent_rdata[IW+1 +: NW];
   assign ent_lvalid = ent_rdata[IW];
   assign ent_link   = ent_rdata[IW-1:0];
   assign out_free   = !rsp_valid_ff || !rsp_stall;

   // control and payload registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= dib_pkg::ST_CLEAR;
         count_ff     <= '0;
         epoch_ff     <= '0;
         clr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         epoch_ff     <= epoch_in;
         clr_ff       <= clr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      v_ff         <= v_in;
      n_ff         <= n_in;
      last_ff      <= last_in;
      bucket_ff    <= bucket_in;
      have_ff      <= have_in;
      hidx_ff      <= hidx_in;
      cur_ff       <= cur_in;
      ridx_ff      <= ridx_in;
      rnew_ff      <= rnew_in;
      rfull_ff     <= rfull_in;
      rsp_index_ff <= rsp_index_in;
      rsp_new_ff   <= rsp_new_in;
      rsp_value_ff <= rsp_value_in;
      rsp_full_ff  <= rsp_full_in;
      rsp_width_ff <= rsp_width_in;
   end

   // sequencer: bucket clear, hash, head read, chain walk, insert, result
   always_comb begin
      state_in     = state_ff;
      v_in         = v_ff;
      n_in         = n_ff;
      last_in      = last_ff;
      bucket_in    = bucket_ff;
      have_in      = have_ff;
      hidx_in      = hidx_ff;
      cur_in       = cur_ff;
      count_in     = count_ff;
      epoch_in     = epoch_ff;
      clr_in       = clr_ff;
      ridx_in      = ridx_ff;
      rnew_in      = rnew_ff;
      rfull_in     = rfull_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_index_in = rsp_index_ff;
      rsp_new_in   = rsp_new_ff;
      rsp_value_in = rsp_value_ff;
      rsp_full_in  = rsp_full_ff;
      rsp_width_in = rsp_width_ff;
      req_stall    = 1'b1;
      hash_start   = 1'b0;
      head_we      = 1'b0;
      head_waddr   = bucket_ff;
      head_wdata   = {1'b1, epoch_ff, count_ff[IW-1:0]};
      head_re      = 1'b0;
      head_raddr   = hash_bucket;
      ent_we       = 1'b0;
      ent_waddr    = count_ff[IW-1:0];
      ent_wdata    = {v_ff, n_ff, have_ff, hidx_ff};
      ent_re       = 1'b0;
      ent_raddr    = hidx_ff;
      case (state_ff)
         dib_pkg::ST_CLEAR: begin
            head_we    = 1'b1;
            head_waddr = clr_ff;
            head_wdata = '0;
            clr_in     = clr_ff + 1'b1;
            if (clr_ff == BW'(dib_pkg::BUCKET_COUNT - 1)) begin
               clr_in   = '0;
               state_in = dib_pkg::ST_IDLE;
            end
         end
         dib_pkg::ST_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               v_in       = req_value & req_mask;
               n_in       = req_n;
               last_in    = req_last_value;
               hash_start = 1'b1;
               state_in   = dib_pkg::ST_HASH;
            end
         end
         dib_pkg::ST_HASH: begin
            if (hash_done) begin
               bucket_in = hash_bucket;
               head_re   = 1'b1;
               state_in  = dib_pkg::ST_HEAD;
            end
         end
         dib_pkg::ST_HEAD: begin
            have_in = head_have;
            hidx_in = head_rdata[IW-1:0];
            cur_in  = head_rdata[IW-1:0];
            if (head_have) begin
               ent_re    = 1'b1;
               ent_raddr = head_rdata[IW-1:0];
               state_in  = dib_pkg::ST_ENTRY;
            end else begin
               state_in = dib_pkg::ST_MISS;
            end
         end
         dib_pkg::ST_ENTRY: begin
            if (ent_n == n_ff && ent_data == v_ff) begin
               ridx_in  = cur_ff;
               rnew_in  = 1'b0;
               rfull_in = 1'b0;
               state_in = dib_pkg::ST_FINISH;
            end else if (ent_lvalid) begin
               ent_re    = 1'b1;
               ent_raddr = ent_link;
               cur_in    = ent_link;
            end else begin
               state_in = dib_pkg::ST_MISS;
            end
         end
         dib_pkg::ST_MISS: begin
            if (count_ff >= CW'(MAX_ENTRIES)) begin
               ridx_in  = '0;
               rnew_in  = 1'b0;
               rfull_in = 1'b1;
            end else begin
               ent_we   = 1'b1;
               head_we  = 1'b1;
               ridx_in  = count_ff[IW-1:0];
               rnew_in  = 1'b1;
               rfull_in = 1'b0;
               count_in = count_ff + 1'b1;
            end
            state_in = dib_pkg::ST_FINISH;
         end
         dib_pkg::ST_FINISH: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_index_in = 12'(ridx_ff);
               rsp_new_in   = rnew_ff;
               rsp_value_in = rnew_ff ? v_ff : '0;
               rsp_full_in  = rfull_ff;
               rsp_width_in = width_for(count_ff);
               state_in     = dib_pkg::ST_IDLE;
               // end of chunk: retire all heads by bumping the epoch
               if (last_ff) begin
                  count_in = '0;
                  epoch_in = epoch_ff + 1'b1;
                  if (epoch_ff == '1) begin
                     state_in = dib_pkg::ST_CLEAR;
                  end
               end
            end
         end
         default: begin
            state_in = dib_pkg::ST_IDLE;
         end
      endcase
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_dict_index  = rsp_index_ff;
   assign rsp_is_new      = rsp_new_ff;
   assign rsp_dict_value  = rsp_value_ff;
   assign rsp_table_full  = rsp_full_ff;
   assign rsp_index_width = rsp_width_ff;
endmodule

/* hw/rtl/dib_checker.sv */
// port-level checks of the dictionary index builder and their bind
`include "dictionary_index_builder_core_assert.svh"

module dib_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_stall,
   input logic [63:0] req_value,
   input logic        req_last_value,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic [11:0] rsp_dict_index,
   input logic        rsp_is_new,
   input logic [63:0] rsp_dict_value,
   input logic        rsp_table_full,
   input logic [3:0]  rsp_index_width,
   input logic        psel,
   input logic        penable,
   input logic        pwrite,
   input logic [2:0]  paddr,
   input logic [31:0] pwdata,
   input logic [31:0] prdata,
   input logic        pready
);
   // a stalled item stays offered with its index and value unchanged
   `DIB_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid)
   `DIB_ASSERT_NEXT(a_rsp_stable, clock, reset, rsp_valid && rsp_stall, $stable(rsp_dict_index) && $stable(rsp_dict_value))
   // overflow inserts nothing and reports index zero
   `DIB_ASSERT_NOW(a_full_item, clock, reset, rsp_valid && rsp_table_full, !rsp_is_new && rsp_dict_index == 12'd0)
   // an inserted item leaves at least one entry
   `DIB_ASSERT_NOW(a_new_width, clock, reset, rsp_valid && rsp_is_new, rsp_index_width != 4'd0)
   // only new items echo their value
   `DIB_ASSERT_NOW(a_echo_zero, clock, reset, rsp_valid && !rsp_is_new, rsp_dict_value == 64'd0)
endmodule

bind dictionary_index_builder_core dib_checker u_dib_checker (.*);
